FILE: rtl/core/ufrr_pkg.sv
// shared types, codes and defaults of the uart frame receiver and responder
package ufrr_pkg;

    localparam int RX_WORDS_DEF = 8;
    localparam int TX_WORDS_DEF = 4;

    // operation codes
    localparam logic [2:0] OP_RX_BYTE = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_SET_TX  = 3'd2;
    localparam logic [2:0] OP_READ_RX = 3'd3;
    localparam logic [2:0] OP_SEND    = 3'd4;

    // status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_DROPPED  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_WRITE_CODE = 2'd0;
    localparam logic [1:0] CFG_READ_CODE  = 2'd1;
    localparam logic [1:0] CFG_CMD_CODE   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

    // configuration reset values
    localparam logic [7:0]  WRITE_CODE_RST = 8'd1;
    localparam logic [7:0]  READ_CODE_RST  = 8'd2;
    localparam logic [7:0]  CMD_CODE_RST   = 8'd3;
    localparam logic [15:0] TIMEOUT_RST    = 16'd100;

    typedef enum logic [2:0] {
        K_IDLE,
        K_WLEN,
        K_WDATA,
        K_READ,
        K_CMD
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEND
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic read_out;
        logic send_init;
        logic send_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       kind_read;
        logic       slot_free;
        logic       send_done;
    } t_dp_sts;

endpackage

FILE: rtl/core/ufrr_in_if.sv
// input item channel
interface ufrr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  rx_byte;
    logic [2:0]  word_index;
    logic [15:0] word_value;

    modport source (output valid, output operation, output rx_byte, output word_index,
                    output word_value, input ready);
    modport sink (input valid, input operation, input rx_byte, input word_index,
                  input word_value, output ready);
endinterface

FILE: rtl/core/ufrr_out_if.sv
// result item channel
interface ufrr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        last_of_run;
    logic [15:0] read_value;
    logic [2:0]  status;

    modport source (output valid, output tx_byte, output tx_valid, output last_of_run,
                    output read_value, output status, input ready);
    modport sink (input valid, input tx_byte, input tx_valid, input last_of_run,
                  input read_value, input status, output ready);
endinterface

FILE: rtl/core/ufrr_ram.sv
// generic single write port ram with registered read
module ufrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ufrr_ctrl.sv
// item sequencing state machine
module ufrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ufrr_pkg::t_dp_sts i_sts,
    output ufrr_pkg::t_dp_cmd o_cmd
);

    ufrr_pkg::t_state r_state;
    ufrr_pkg::t_state n_state;
    logic             sending;

    assign sending = (i_sts.op == ufrr_pkg::OP_SEND) ||
                     ((i_sts.op == ufrr_pkg::OP_RX_BYTE) && i_sts.kind_read);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufrr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufrr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ufrr_pkg::S_EXEC;
                end
            end
            ufrr_pkg::S_EXEC: begin
                if (sending) begin
                    n_state = ufrr_pkg::S_SEND;
                end else if (i_sts.op == ufrr_pkg::OP_READ_RX) begin
                    n_state = ufrr_pkg::S_READ;
                end else if (i_sts.slot_free) begin
                    n_state = ufrr_pkg::S_IDLE;
                end
            end
            ufrr_pkg::S_READ: begin
                if (i_sts.slot_free) begin
                    n_state = ufrr_pkg::S_IDLE;
                end
            end
            ufrr_pkg::S_SEND: begin
                if (i_sts.slot_free && i_sts.send_done) begin
                    n_state = ufrr_pkg::S_IDLE;
                end
            end
            default: n_state = ufrr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ufrr_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ufrr_pkg::S_EXEC: begin
                if (sending) begin
                    o_cmd.send_init = 1'b1;
                end else if (i_sts.op != ufrr_pkg::OP_READ_RX) begin
                    o_cmd.exec = i_sts.slot_free;
                end
            end
            ufrr_pkg::S_READ: begin
                o_cmd.read_out = i_sts.slot_free;
            end
            ufrr_pkg::S_SEND: begin
                o_cmd.send_step = i_sts.slot_free;
            end
            default: o_cmd = '0;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_read_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ufrr_pkg::S_READ) |->
            ($past(r_state) == ufrr_pkg::S_EXEC || $past(r_state) == ufrr_pkg::S_READ))
        else $error("read state entered without execution");

    a_send_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ufrr_pkg::S_SEND && i_sts.slot_free && i_sts.send_done) |=>
            (r_state == ufrr_pkg::S_IDLE))
        else $error("frame run did not end after last byte");

endmodule

FILE: rtl/core/ufrr_dp.sv
// parser, word stores, frame sender and output register
module ufrr_dp #(
    parameter int RX_WORDS = ufrr_pkg::RX_WORDS_DEF,
    parameter int TX_WORDS = ufrr_pkg::TX_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ufrr_pkg::t_dp_cmd i_cmd,
    output ufrr_pkg::t_dp_sts o_sts,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_rx_byte,
    input  logic [2:0]        i_word_index,
    input  logic [15:0]       i_word_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_tx_byte,
    output logic              o_tx_valid,
    output logic              o_last_of_run,
    output logic [15:0]       o_read_value,
    output logic [2:0]        o_status,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam int AW       = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;
    localparam int TAW      = (TX_WORDS > 1) ? $clog2(TX_WORDS) : 1;
    localparam int PW       = $clog2(2 * RX_WORDS);
    localparam int SEND_N   = 2 + 2 * TX_WORDS;
    localparam int SW       = $clog2(SEND_N);
    localparam logic [7:0]    RX_LEN   = 8'(2 * RX_WORDS);
    localparam logic [7:0]    TX_LEN   = 8'(2 * TX_WORDS);
    localparam logic [PW-1:0] POS_LAST = PW'(2 * RX_WORDS - 1);
    localparam logic [SW-1:0] SEND_LAST = SW'(SEND_N - 1);

    // latched item
    logic [2:0]  r_op;
    logic [7:0]  r_byte;
    logic [2:0]  r_index;
    logic [15:0] r_value;

    // configuration
    logic [7:0]  r_wcode;
    logic [7:0]  r_rcode;
    logic [7:0]  r_ccode;
    logic [15:0] r_tmo;

    // parser
    ufrr_pkg::t_kind r_kind;
    ufrr_pkg::t_kind n_kind;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    logic [15:0]     r_timer;
    logic [15:0]     n_timer;
    logic [2:0]      exec_st;
    logic [15:0]     tmo_load;
    logic            wr_lo;
    logic            wr_hi;

    // stores
    logic [15:0]         r_tx [TX_WORDS];
    logic [RX_WORDS-1:0] r_lo_vld;
    logic [RX_WORDS-1:0] r_hi_vld;
    logic                r_rd_lo_ok;
    logic                r_rd_hi_ok;
    logic                r_rd_in;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          lo_rdata;
    logic [7:0]          hi_rdata;
    logic [15:0]         rd_word;
    logic                tx_in_range;

    // frame sender
    logic [SW-1:0] r_send_idx;
    logic [2:0]    r_send_st;
    logic [SW-1:0] wsel;
    logic [15:0]   send_word;
    logic [7:0]    send_byte;
    logic          send_done;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_tx_byte;
    logic        r_out_tx_valid;
    logic        r_out_last_of_run;
    logic [15:0] r_out_read_value;
    logic [2:0]  r_out_status;
    logic        slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign tmo_load    = (r_tmo == '0) ? 16'd1 : r_tmo;
    assign tx_in_range = int'(r_index) < TX_WORDS;

    assign o_sts.op        = r_op;
    assign o_sts.kind_read = (r_kind == ufrr_pkg::K_READ);
    assign o_sts.slot_free = slot_free;
    assign o_sts.send_done = send_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_byte  <= i_rx_byte;
            r_index <= i_word_index;
            r_value <= i_word_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcode <= ufrr_pkg::WRITE_CODE_RST;
            r_rcode <= ufrr_pkg::READ_CODE_RST;
            r_ccode <= ufrr_pkg::CMD_CODE_RST;
            r_tmo   <= ufrr_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ufrr_pkg::CFG_WRITE_CODE: r_wcode <= i_cfg_data[7:0];
                ufrr_pkg::CFG_READ_CODE:  r_rcode <= i_cfg_data[7:0];
                ufrr_pkg::CFG_CMD_CODE:   r_ccode <= i_cfg_data[7:0];
                ufrr_pkg::CFG_TIMEOUT:    r_tmo   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // byte parser and timer
    always_comb begin
        n_kind  = r_kind;
        n_pos   = r_pos;
        n_timer = r_timer;
        exec_st = ufrr_pkg::ST_NONE;
        wr_lo   = 1'b0;
        wr_hi   = 1'b0;
        case (r_op)
            ufrr_pkg::OP_RX_BYTE: begin
                unique case (r_kind)
                    ufrr_pkg::K_IDLE: begin
                        exec_st = ufrr_pkg::ST_ACCEPTED;
                        n_timer = tmo_load;
                        if (r_byte == r_wcode) begin
                            n_kind = ufrr_pkg::K_WLEN;
                        end else if (r_byte == r_rcode) begin
                            n_kind = ufrr_pkg::K_READ;
                        end else if (r_byte == r_ccode) begin
                            n_kind = ufrr_pkg::K_CMD;
                        end else begin
                            n_timer = r_timer;
                            exec_st = ufrr_pkg::ST_DROPPED;
                        end
                    end
                    ufrr_pkg::K_CMD: begin
                        n_kind  = ufrr_pkg::K_IDLE;
                        n_timer = '0;
                        exec_st = ufrr_pkg::ST_DONE;
                    end
                    ufrr_pkg::K_WLEN: begin
                        n_pos = '0;
                        if (r_byte == RX_LEN) begin
                            n_kind  = ufrr_pkg::K_WDATA;
                            n_timer = tmo_load;
                            exec_st = ufrr_pkg::ST_ACCEPTED;
                        end else begin
                            n_kind  = ufrr_pkg::K_IDLE;
                            n_timer = '0;
                            exec_st = ufrr_pkg::ST_BAD_LEN;
                        end
                    end
                    ufrr_pkg::K_WDATA: begin
                        wr_lo = !r_pos[0];
                        wr_hi = r_pos[0];
                        if (r_pos == POS_LAST) begin
                            n_kind  = ufrr_pkg::K_IDLE;
                            n_pos   = '0;
                            n_timer = '0;
                            exec_st = ufrr_pkg::ST_DONE;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_timer = tmo_load;
                            exec_st = ufrr_pkg::ST_ACCEPTED;
                        end
                    end
                    default: ;
                endcase
            end
            ufrr_pkg::OP_TICK: begin
                if (r_timer != '0) begin
                    n_timer = r_timer - 1'b1;
                    if (r_timer == 16'd1) begin
                        n_kind  = ufrr_pkg::K_IDLE;
                        n_pos   = '0;
                        exec_st = ufrr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= ufrr_pkg::K_IDLE;
            r_pos   <= '0;
            r_timer <= '0;
        end else if (i_cmd.exec) begin
            r_kind  <= n_kind;
            r_pos   <= n_pos;
            r_timer <= n_timer;
        end else if (i_cmd.send_init && r_op == ufrr_pkg::OP_RX_BYTE) begin
            r_kind  <= ufrr_pkg::K_IDLE;
            r_pos   <= '0;
            r_timer <= '0;
        end
    end

    // receive word store, one ram per byte lane
    assign ram_waddr = AW'(r_pos >> 1);
    assign ram_raddr = AW'(r_index);

    ufrr_ram #(.WIDTH(8), .DEPTH(RX_WORDS)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && wr_lo),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_raddr (ram_raddr),
        .o_rdata (lo_rdata)
    );

    ufrr_ram #(.WIDTH(8), .DEPTH(RX_WORDS)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && wr_hi),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_raddr (ram_raddr),
        .o_rdata (hi_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_vld <= '0;
            r_hi_vld <= '0;
        end else if (i_cmd.exec) begin
            if (wr_lo) begin
                r_lo_vld[ram_waddr] <= 1'b1;
            end
            if (wr_hi) begin
                r_hi_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_in    <= int'(r_index) < RX_WORDS;
        r_rd_lo_ok <= r_lo_vld[ram_raddr];
        r_rd_hi_ok <= r_hi_vld[ram_raddr];
    end

    assign rd_word = r_rd_in ? {(r_rd_hi_ok ? hi_rdata : 8'd0),
                                (r_rd_lo_ok ? lo_rdata : 8'd0)} : 16'd0;

    // transmit word store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TX_WORDS; i++) begin
                r_tx[i] <= '0;
            end
        end else if (i_cmd.exec && r_op == ufrr_pkg::OP_SET_TX && tx_in_range) begin
            r_tx[TAW'(r_index)] <= r_value;
        end
    end

    // frame sender
    assign wsel      = r_send_idx - SW'(2);
    assign send_word = r_tx[TAW'(wsel >> 1)];
    assign send_done = (r_send_idx == SEND_LAST);

    always_comb begin
        if (r_send_idx == '0) begin
            send_byte = r_wcode;
        end else if (r_send_idx == SW'(1)) begin
            send_byte = TX_LEN;
        end else if (wsel[0]) begin
            send_byte = send_word[15:8];
        end else begin
            send_byte = send_word[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_idx <= '0;
            r_send_st  <= ufrr_pkg::ST_NONE;
        end else if (i_cmd.send_init) begin
            r_send_idx <= '0;
            r_send_st  <= (r_op == ufrr_pkg::OP_RX_BYTE) ? ufrr_pkg::ST_DONE
                                                         : ufrr_pkg::ST_NONE;
        end else if (i_cmd.send_step) begin
            r_send_idx <= r_send_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.read_out || i_cmd.send_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_tx_byte     <= '0;
            r_out_tx_valid    <= 1'b0;
            r_out_last_of_run <= 1'b1;
            r_out_read_value  <= '0;
            r_out_status      <= exec_st;
        end else if (i_cmd.read_out) begin
            r_out_tx_byte     <= '0;
            r_out_tx_valid    <= 1'b0;
            r_out_last_of_run <= 1'b1;
            r_out_read_value  <= rd_word;
            r_out_status      <= ufrr_pkg::ST_NONE;
        end else if (i_cmd.send_step) begin
            r_out_tx_byte     <= send_byte;
            r_out_tx_valid    <= 1'b1;
            r_out_last_of_run <= send_done;
            r_out_read_value  <= '0;
            r_out_status      <= r_send_st;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_out_tx_byte;
    assign o_tx_valid    = r_out_tx_valid;
    assign o_last_of_run = r_out_last_of_run;
    assign o_read_value  = r_out_read_value;
    assign o_status      = r_out_status;

    a_timer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == ufrr_pkg::K_IDLE) == (r_timer == '0))
        else $error("timer running state disagrees with parser state");

    a_send_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.send_step |=> (r_out_valid && r_out_tx_valid))
        else $error("frame byte result not marked as transmit byte");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_out_valid && r_out_last_of_run && !r_out_tx_valid))
        else $error("single result not marked last");

endmodule

FILE: rtl/core/uart_frame_receiver_responder.sv
// uart frame receiver and responder top level
// an item is latched on accept and executed into the output register for bytes, ticks,
// word writes; a receive word read adds a read state (registered ram read port)
// frame send: set up in the execute state, then one byte per cycle unless the output stalls, 2+2*TX_WORDS bytes
// no new item is accepted until the last one has been executed, read out or sent
// synchronous active-low reset restores register defaults, idles the parser,
// zeroes the transmit words and marks every receive word as zero
module uart_frame_receiver_responder #(
    parameter int RX_WORDS = ufrr_pkg::RX_WORDS_DEF,
    parameter int TX_WORDS = ufrr_pkg::TX_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufrr_in_if.sink     i_in,
    ufrr_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    ufrr_pkg::t_dp_cmd cmd;
    ufrr_pkg::t_dp_sts sts;
    logic              in_ready;

    assign i_in.ready = in_ready;

    ufrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ufrr_dp #(
        .RX_WORDS (RX_WORDS),
        .TX_WORDS (TX_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_in.operation),
        .i_rx_byte     (i_in.rx_byte),
        .i_word_index  (i_in.word_index),
        .i_word_value  (i_in.word_value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_tx_byte     (o_out.tx_byte),
        .o_tx_valid    (o_out.tx_valid),
        .o_last_of_run (o_out.last_of_run),
        .o_read_value  (o_out.read_value),
        .o_status      (o_out.status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

endmodule
